FILE: hdl/lpf_pkg.sv
`default_nettype none

package lpf_pkg;

    // field and datapath widths
    localparam int CH_W   = 8;
    localparam int BR_W   = 7;
    localparam int PROF_W = 2;
    localparam int IDX_W  = 2;
    localparam int L_W    = 11;
    localparam int N_W    = 57;
    localparam int DV_W   = 46;
    localparam int WORD_W = 32;
    localparam int NUM_CH = 6;

    // register indexes
    localparam logic [IDX_W-1:0] REG_BRIGHT  = 2'd0;
    localparam logic [IDX_W-1:0] REG_PROFILE = 2'd1;
    localparam logic [IDX_W-1:0] REG_FORMAT  = 2'd2;

    // profile codes
    localparam logic [PROF_W-1:0] PROF_LINEAR = 2'd0;
    localparam logic [PROF_W-1:0] PROF_GAMMA  = 2'd1;
    localparam logic [PROF_W-1:0] PROF_CIE    = 2'd2;
    localparam logic [PROF_W-1:0] PROF_ALT    = 2'd3;

    // register reset values
    localparam logic [BR_W-1:0]   BRIGHT_RST = 7'd100;
    localparam logic [PROF_W-1:0] PROF_RST   = PROF_GAMMA;
    localparam logic              FMT_RST    = 1'b0;

    // colour correction constants
    localparam logic [15:0]     C_S_OFF    = 16'd4080;
    localparam logic [14:0]     C_T_KNEE   = 15'd2040;
    localparam logic [14:0]     C_T_SAT    = 15'd25500;
    localparam logic [26:0]     C_LIN_MUL  = 27'd40940;
    localparam logic [26:0]     C_LIN_ADD  = 27'd2300865;
    localparam logic [26:0]     C_GAM_ADD  = 27'd32512;
    localparam logic [DV_W-1:0] C_DV_GAM   = 46'd65025;
    localparam logic [DV_W-1:0] C_DV_LIN   = 46'd4601730;
    localparam logic [DV_W-1:0] C_DV_CUB   = 46'd51763603824000;
    localparam logic [DV_W-1:0] C_HALF_CUB = 46'd25881801912000;

    typedef enum logic [1:0] {
        MODE_LIN,
        MODE_GAM,
        MODE_CIE
    } t_mode;

    typedef enum logic [1:0] {
        DSEL_GAM,
        DSEL_LIN,
        DSEL_CUB
    } t_dsel;

    typedef struct packed {
        logic [CH_W-1:0] chan;
        logic            sat;
    } t_side;

    // effective correction for a profile and word format
    function automatic t_mode f_mode(logic [PROF_W-1:0] prof, logic fmt11);
        t_mode m;
        case (prof)
            PROF_LINEAR: m = MODE_LIN;
            PROF_GAMMA:  m = MODE_GAM;
            PROF_CIE:    m = MODE_CIE;
            PROF_ALT:    m = fmt11 ? MODE_CIE : MODE_GAM;
            default:     m = MODE_GAM;
        endcase
        return m;
    endfunction

    // divisor for each branch of the correction
    function automatic logic [DV_W-1:0] f_divisor(t_dsel d);
        logic [DV_W-1:0] v;
        case (d)
            DSEL_GAM: v = C_DV_GAM;
            DSEL_LIN: v = C_DV_LIN;
            DSEL_CUB: v = C_DV_CUB;
            default:  v = C_DV_GAM;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/lpf_lane.sv
`default_nettype none

module lpf_lane (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [lpf_pkg::CH_W-1:0]    i_chan,
    input  logic [lpf_pkg::BR_W-1:0]    i_bright,
    input  lpf_pkg::t_mode              i_mode,
    output logic [lpf_pkg::N_W-1:0]     o_num,
    output lpf_pkg::t_dsel              o_dsel,
    output lpf_pkg::t_side              o_side
);
    import lpf_pkg::*;

    logic [CH_W-1:0] r_c1, r_c2, r_c3;
    logic [15:0]     r_p1;
    logic [15:0]     r_s2;
    logic [30:0]     r_sq2;
    logic [26:0]     r_ns2, r_ns3;
    logic            r_knee2, r_knee3, r_sat2, r_sat3, r_gam2, r_gam3;
    logic [45:0]     r_cube3;
    logic [N_W-1:0]  r_num4;
    t_dsel           r_dsel4;
    t_side           r_side4;

    logic [15:0]     w_sq;
    logic [14:0]     w_cb;
    logic [14:0]     w_t;
    logic [15:0]     w_s;
    logic [31:0]     w_s2;
    logic [26:0]     w_ngam, w_nlin;
    logic [45:0]     w_cube;
    logic [57:0]     w_big;
    logic [N_W-1:0]  n_num;
    t_dsel           n_dsel;

    // stage 1: channel squared or channel times brightness
    assign w_sq = 16'(i_chan) * 16'(i_chan);
    assign w_cb = 15'(i_chan) * 15'(i_bright);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c1 <= i_chan;
            r_p1 <= (i_mode == MODE_GAM) ? w_sq : {1'b0, w_cb};
        end
    end

    // stage 2: gamma and low-segment numerators, square of offset level
    assign w_t    = r_p1[14:0];
    assign w_s    = 16'(w_t) + C_S_OFF;
    assign w_s2   = 32'(w_s) * 32'(w_s);
    assign w_ngam = (27'(r_p1) << 8) - 27'(r_p1) + C_GAM_ADD;
    assign w_nlin = 27'(w_t[10:0]) * C_LIN_MUL + C_LIN_ADD;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c2    <= r_c1;
            r_s2    <= w_s;
            r_sq2   <= w_s2[30:0];
            r_ns2   <= (i_mode == MODE_GAM) ? w_ngam : w_nlin;
            r_knee2 <= (w_t <= C_T_KNEE);
            r_sat2  <= (w_t >= C_T_SAT);
            r_gam2  <= (i_mode == MODE_GAM);
        end
    end

    // stage 3: cube of offset level
    assign w_cube = 46'(r_sq2) * 46'(r_s2);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c3    <= r_c2;
            r_cube3 <= w_cube;
            r_ns3   <= r_ns2;
            r_knee3 <= r_knee2;
            r_sat3  <= r_sat2;
            r_gam3  <= r_gam2;
        end
    end

    // stage 4: final numerator and divisor choice
    assign w_big = (58'(r_cube3) << 12) - (58'(r_cube3) << 1) + 58'(C_HALF_CUB);

    always_comb begin
        if (r_gam3) begin
            n_num  = N_W'(r_ns3);
            n_dsel = DSEL_GAM;
        end else if (r_knee3) begin
            n_num  = N_W'(r_ns3);
            n_dsel = DSEL_LIN;
        end else begin
            n_num  = r_sat3 ? '0 : w_big[N_W-1:0];
            n_dsel = DSEL_CUB;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num4       <= n_num;
            r_dsel4      <= n_dsel;
            r_side4.chan <= r_c3;
            r_side4.sat  <= r_sat3 && !r_gam3 && !r_knee3;
        end
    end

    assign o_num  = r_num4;
    assign o_dsel = r_dsel4;
    assign o_side = r_side4;

endmodule

`default_nettype wire

FILE: hdl/lpf_div.sv
`default_nettype none

module lpf_div #(
    parameter int P_BITS = 2
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [lpf_pkg::N_W-1:0]   i_num,
    input  lpf_pkg::t_dsel            i_dsel,
    input  lpf_pkg::t_side            i_side,
    output logic [lpf_pkg::L_W-1:0]   o_quot,
    output lpf_pkg::t_side            o_side
);
    import lpf_pkg::*;

    localparam int NSTG = (L_W + P_BITS - 1) / P_BITS;

    logic [N_W-1:0] r_rem  [NSTG];
    logic [L_W-1:0] r_q    [NSTG];
    t_dsel          r_dsel [NSTG];
    t_side          r_side [NSTG];

    // restoring division, up to P_BITS quotient bits per stage, msb first
    for (genvar k = 0; k < NSTG; k++) begin : g_stg
        localparam int HI = L_W - 1 - k * P_BITS;
        localparam int LO = (HI - P_BITS + 1 > 0) ? HI - P_BITS + 1 : 0;

        logic [N_W-1:0] w_rem_in, n_rem, w_dv;
        logic [L_W-1:0] w_q_in, n_q;
        t_dsel          w_dsel_in;
        t_side          w_side_in;

        if (k == 0) begin : g_first
            assign w_rem_in  = i_num;
            assign w_q_in    = '0;
            assign w_dsel_in = i_dsel;
            assign w_side_in = i_side;
        end else begin : g_next
            assign w_rem_in  = r_rem[k-1];
            assign w_q_in    = r_q[k-1];
            assign w_dsel_in = r_dsel[k-1];
            assign w_side_in = r_side[k-1];
        end

        assign w_dv = N_W'(f_divisor(w_dsel_in));

        always_comb begin
            n_rem = w_rem_in;
            n_q   = w_q_in;
            for (int b = HI; b >= LO; b--) begin
                if (n_rem >= (w_dv << b)) begin
                    n_rem = n_rem - (w_dv << b);
                    n_q[b] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_q[k]    <= n_q;
                r_dsel[k] <= w_dsel_in;
                r_side[k] <= w_side_in;
            end
        end
    end

    assign o_quot = r_q[NSTG-1];
    assign o_side = r_side[NSTG-1];

endmodule

`default_nettype wire

FILE: hdl/lpf_pack.sv
`default_nettype none

module lpf_pack (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_valid,
    output logic                                        o_ready,
    input  logic [lpf_pkg::NUM_CH-1:0][lpf_pkg::L_W-1:0] i_quot,
    input  lpf_pkg::t_side [lpf_pkg::NUM_CH-1:0]        i_side,
    input  lpf_pkg::t_mode                              i_mode,
    input  logic                                        i_fmt11,
    output logic                                        o_valid,
    input  logic                                        i_ready,
    output logic [lpf_pkg::WORD_W-1:0]                  o_word,
    output logic                                        o_last
);
    import lpf_pkg::*;

    logic                          r_full;
    logic [1:0]                    r_cnt;
    logic                          r_three;
    logic [WORD_W-1:0]             r_w0, r_w1, r_w2;

    logic [NUM_CH-1:0][L_W-1:0]    w_r11;
    logic [NUM_CH-1:0][CH_W-1:0]   w_r8;
    logic [WORD_W-1:0]             n_w0, n_w1, n_w2;
    logic                          w_take;

    // per-channel result in both formats
    always_comb begin
        for (int j = 0; j < NUM_CH; j++) begin
            case (i_mode)
                MODE_LIN: begin
                    w_r11[j] = {i_side[j].chan, 3'b000};
                    w_r8[j]  = i_side[j].chan;
                end
                MODE_GAM: begin
                    w_r11[j] = {i_quot[j][CH_W-1:0], 3'b000};
                    w_r8[j]  = i_quot[j][CH_W-1:0];
                end
                MODE_CIE: begin
                    w_r11[j] = i_side[j].sat ? '1 : i_quot[j];
                    w_r8[j]  = w_r11[j][L_W-1:3];
                end
                default: begin
                    w_r11[j] = {i_side[j].chan, 3'b000};
                    w_r8[j]  = i_side[j].chan;
                end
            endcase
        end
    end

    // word packing
    always_comb begin
        if (i_fmt11) begin
            n_w0 = {w_r11[2][9:0], w_r11[1], w_r11[0]};
            n_w1 = {w_r11[5][8:0], w_r11[4], w_r11[3], w_r11[2][10]};
        end else begin
            n_w0 = {8'd0, w_r8[2], w_r8[1], w_r8[0]};
            n_w1 = {8'd0, w_r8[5], w_r8[4], w_r8[3]};
        end
        n_w2 = {30'd0, w_r11[5][10:9]};
    end

    // take a new pair when empty or when the last word goes out
    assign w_take  = !r_full || (i_ready && (r_cnt == 2'd1));
    assign o_ready = w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
            r_cnt  <= 2'd0;
        end else if (w_take) begin
            r_full <= i_valid;
            r_cnt  <= i_valid ? (i_fmt11 ? 2'd3 : 2'd2) : 2'd0;
        end else if (i_ready) begin
            r_cnt  <= r_cnt - 2'd1;
        end
    end

    // word shift register
    always_ff @(posedge i_clk) begin
        if (w_take && i_valid) begin
            r_w0    <= n_w0;
            r_w1    <= n_w1;
            r_w2    <= n_w2;
            r_three <= i_fmt11;
        end else if (r_full && i_ready) begin
            r_w0 <= r_w1;
            r_w1 <= r_w2;
        end
    end

    assign o_valid = r_full;
    assign o_word  = r_w0;
    assign o_last  = (r_cnt == 2'd1);

    // word count stays within the pair's format
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |-> (r_cnt != 2'd0) && (r_three || (r_cnt != 2'd3)))
        else $error("word count out of range");

    // a word that is not the last is followed by another
    a_more_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last |=> o_valid)
        else $error("pair ended before its last word");

    // 8-bit words leave the top byte clear
    a_top_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !r_three |-> (o_word[31:24] == 8'd0))
        else $error("8-bit word has data in top byte");

    // third 11-bit word carries two bits only
    a_tail_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && r_three && o_last |-> (o_word[31:2] == 30'd0))
        else $error("third 11-bit word has stray bits");

endmodule

`default_nettype wire

FILE: hdl/led_panel_pixel_pair_formatter.sv
`default_nettype none

// channel   direction  handshake                  payload
// in        request    i_in_valid / o_in_ready    i_upper_*, i_lower_* (8 bits each)
// out       request    o_out_valid / i_out_ready  o_packed_word, o_last_word
// cfg       write      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// a pair can enter every cycle until the pipeline fills; sustained, the serialiser sets
// the rate: it sends one word a cycle while the receiver is ready, two words per pair
// in 8-bit format and three in 11-bit format
// reset is synchronous, active low: clears all valids, sets brightness 100, gamma, 8-bit
// a stalled output freezes the pipeline once a pair waits at its end; config is always ready

module led_panel_pixel_pair_formatter #(
    parameter int P_DIV_BITS = 2
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [lpf_pkg::IDX_W-1:0]      i_cfg_index,
    input  logic [lpf_pkg::BR_W-1:0]       i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [lpf_pkg::CH_W-1:0]       i_upper_red,
    input  logic [lpf_pkg::CH_W-1:0]       i_upper_green,
    input  logic [lpf_pkg::CH_W-1:0]       i_upper_blue,
    input  logic [lpf_pkg::CH_W-1:0]       i_lower_red,
    input  logic [lpf_pkg::CH_W-1:0]       i_lower_green,
    input  logic [lpf_pkg::CH_W-1:0]       i_lower_blue,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [lpf_pkg::WORD_W-1:0]     o_packed_word,
    output logic                           o_last_word
);
    import lpf_pkg::*;

    localparam int NSTG  = (L_W + P_DIV_BITS - 1) / P_DIV_BITS;
    localparam int DEPTH = 4 + NSTG;

    logic [BR_W-1:0]              r_bright;
    logic [PROF_W-1:0]            r_profile;
    logic                         r_format;
    logic [DEPTH-1:0]             r_vld;

    t_mode                        w_mode;
    logic                         w_adv;
    logic                         w_pack_ready;
    logic [NUM_CH-1:0][CH_W-1:0]  w_chan;
    logic [NUM_CH-1:0][N_W-1:0]   w_num;
    t_dsel                        w_dsel [NUM_CH];
    t_side [NUM_CH-1:0]           w_side_f;
    t_side [NUM_CH-1:0]           w_side_d;
    logic [NUM_CH-1:0][L_W-1:0]   w_quot;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bright  <= BRIGHT_RST;
            r_profile <= PROF_RST;
            r_format  <= FMT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_BRIGHT:  r_bright  <= i_cfg_data;
                REG_PROFILE: r_profile <= i_cfg_data[PROF_W-1:0];
                REG_FORMAT:  r_format  <= i_cfg_data[0];
                default:     ;
            endcase
        end
    end

    assign w_mode = f_mode(r_profile, r_format);

    // pipeline advance and valid tracking
    assign w_adv      = !r_vld[DEPTH-1] || w_pack_ready;
    assign o_in_ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[DEPTH-2:0], i_in_valid};
        end
    end

    assign w_chan[0] = i_upper_red;
    assign w_chan[1] = i_upper_green;
    assign w_chan[2] = i_upper_blue;
    assign w_chan[3] = i_lower_red;
    assign w_chan[4] = i_lower_green;
    assign w_chan[5] = i_lower_blue;

    // one correction lane per channel
    for (genvar j = 0; j < NUM_CH; j++) begin : g_lane
        lpf_lane u_lane (
            .i_clk    (i_clk),
            .i_en     (w_adv),
            .i_chan   (w_chan[j]),
            .i_bright (r_bright),
            .i_mode   (w_mode),
            .o_num    (w_num[j]),
            .o_dsel   (w_dsel[j]),
            .o_side   (w_side_f[j])
        );

        lpf_div #(
            .P_BITS (P_DIV_BITS)
        ) u_div (
            .i_clk  (i_clk),
            .i_en   (w_adv),
            .i_num  (w_num[j]),
            .i_dsel (w_dsel[j]),
            .i_side (w_side_f[j]),
            .o_quot (w_quot[j]),
            .o_side (w_side_d[j])
        );
    end

    // word serialiser
    lpf_pack u_pack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vld[DEPTH-1]),
        .o_ready (w_pack_ready),
        .i_quot  (w_quot),
        .i_side  (w_side_d),
        .i_mode  (w_mode),
        .i_fmt11 (r_format),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_word  (o_packed_word),
        .o_last  (o_last_word)
    );

    // an accepted request enters the first stage
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> r_vld[0])
        else $error("accepted request lost at pipeline entry");

    // a pair waiting at the pipeline end is kept until the serialiser takes it
    a_hold_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[DEPTH-1] && !w_pack_ready |=> r_vld[DEPTH-1])
        else $error("stalled pair dropped at pipeline end");

endmodule

`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 100ps

module tb;
    import lpf_pkg::*;

    localparam int IDLE_LIMIT = 3000;
    localparam int HOLD_LEN   = 90;

    // one pixel pair as it enters the block
    typedef struct packed {
        logic [CH_W-1:0] ur;
        logic [CH_W-1:0] ug;
        logic [CH_W-1:0] ub;
        logic [CH_W-1:0] lr;
        logic [CH_W-1:0] lg;
        logic [CH_W-1:0] lb;
    } t_pixel_pair;

    // one panel word as it leaves the block
    typedef struct {
        logic [WORD_W-1:0] word;
        logic              last;
    } t_panel_word;

    // tracks the colour registers and the panel words still owed by the block
    class panel_word_board;
        logic [BR_W-1:0]   bright;
        logic [PROF_W-1:0] profile;
        logic              fmt11;
        t_panel_word       due[$];
        int                errors;

        function new();
            bright  = BRIGHT_RST;
            profile = PROF_RST;
            fmt11   = FMT_RST;
            errors  = 0;
        endfunction

        function void set_reg(logic [IDX_W-1:0] idx, logic [BR_W-1:0] data);
            case (idx)
                REG_BRIGHT:  bright  = data;
                REG_PROFILE: profile = data[PROF_W-1:0];
                REG_FORMAT:  fmt11   = data[0];
                default: ;
            endcase
        endfunction

        // cie1931 luminance in exact rationals, rounded half up, clamped to 11 bits
        function logic [L_W-1:0] cie_luma(logic [CH_W-1:0] c);
            longint unsigned t;
            longint unsigned s;
            longint unsigned v;
            t = 64'(c) * 64'(bright);
            if (t <= 64'd2040) begin
                v = (64'd40940 * t + 64'd2300865) / 64'd4601730;
            end else begin
                s = t + 64'd4080;
                v = (64'd4094 * s * s * s + 64'd25881801912000) / 64'd51763603824000;
            end
            if (v > 64'd2047)
                v = 64'd2047;
            return v[L_W-1:0];
        endfunction

        // square-law gamma, rounded to nearest
        function logic [CH_W-1:0] square_gamma(logic [CH_W-1:0] c);
            int unsigned cc;
            int unsigned v;
            cc = c;
            v  = (cc * cc * 255 + 32512) / 65025;
            if (v > 255)
                v = 255;
            return v[CH_W-1:0];
        endfunction

        function logic [CH_W-1:0] correct8(logic [CH_W-1:0] c);
            logic [L_W-1:0] l;
            case (profile)
                PROF_LINEAR: return c;
                PROF_CIE: begin
                    l = cie_luma(c);
                    return l[L_W-1:3];
                end
                default: return square_gamma(c);
            endcase
        endfunction

        function logic [L_W-1:0] correct11(logic [CH_W-1:0] c);
            case (profile)
                PROF_LINEAR: return {c, 3'b000};
                PROF_GAMMA:  return {square_gamma(c), 3'b000};
                default:     return cie_luma(c);
            endcase
        endfunction

        function void push_word(logic [WORD_W-1:0] w, logic last);
            t_panel_word e;
            e.word = w;
            e.last = last;
            due.push_back(e);
        endfunction

        // accepted pixel pair: work out the panel words it must produce
        function void note_pair(t_pixel_pair p);
            logic [L_W-1:0] ur, ug, ub, lr, lg, lb;
            if (!fmt11) begin
                push_word({8'h00, correct8(p.ub), correct8(p.ug), correct8(p.ur)}, 1'b0);
                push_word({8'h00, correct8(p.lb), correct8(p.lg), correct8(p.lr)}, 1'b1);
            end else begin
                ur = correct11(p.ur);
                ug = correct11(p.ug);
                ub = correct11(p.ub);
                lr = correct11(p.lr);
                lg = correct11(p.lg);
                lb = correct11(p.lb);
                push_word({ub[9:0], ug, ur}, 1'b0);
                push_word({lb[8:0], lg, lr, ub[10]}, 1'b0);
                push_word({30'd0, lb[10:9]}, 1'b1);
            end
        endfunction

        // accepted panel word against the oldest one owed
        function void check_word(logic [WORD_W-1:0] w, logic last);
            t_panel_word e;
            if (due.size() == 0) begin
                $error("unexpected word: packed_word %h last_word %b", w, last);
                errors++;
            end else begin
                e = due.pop_front();
                if (w !== e.word) begin
                    $error("packed_word expected %h actual %h", e.word, w);
                    errors++;
                end
                if (last !== e.last) begin
                    $error("last_word expected %b actual %b", e.last, last);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [IDX_W-1:0]    i_cfg_index;
    logic [BR_W-1:0]     i_cfg_data;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [CH_W-1:0]     i_upper_red;
    logic [CH_W-1:0]     i_upper_green;
    logic [CH_W-1:0]     i_upper_blue;
    logic [CH_W-1:0]     i_lower_red;
    logic [CH_W-1:0]     i_lower_green;
    logic [CH_W-1:0]     i_lower_blue;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [WORD_W-1:0]   o_packed_word;
    logic                o_last_word;

    panel_word_board board = new();

    int send_idle_pct = 12;
    int recv_idle_pct = 81;
    int hold_count    = 0;

    led_panel_pixel_pair_formatter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_upper_red   (i_upper_red),
        .i_upper_green (i_upper_green),
        .i_upper_blue  (i_upper_blue),
        .i_lower_red   (i_lower_red),
        .i_lower_green (i_lower_green),
        .i_lower_blue  (i_lower_blue),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_packed_word (o_packed_word),
        .o_last_word   (o_last_word)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // word receiver: checks every accepted word, stalls at random or for a long hold
    initial begin
        int taken;
        int hold_left;
        taken       = 0;
        hold_left   = 0;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready)
                board.check_word(o_packed_word, o_last_word);
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (taken != hold_count) begin
                taken     = hold_count;
                hold_left = HOLD_LEN - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // watchdog on cycles with no request accepted anywhere
    initial begin
        int idle_cnt;
        idle_cnt = 0;
        while (idle_cnt < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready))
                idle_cnt = 0;
            else
                idle_cnt++;
        end
        $display("led_panel_pixel_pair_formatter test failed");
        $finish;
    end

    // offer one pixel pair, after a random gap, and wait for it to be taken
    task automatic send_pair(input t_pixel_pair p);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_upper_red   <= p.ur;
        i_upper_green <= p.ug;
        i_upper_blue  <= p.ub;
        i_lower_red   <= p.lr;
        i_lower_green <= p.lg;
        i_lower_blue  <= p.lb;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_pair(p);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [BR_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_reg(idx, data);
    endtask

    // drain the block, then load all three colour registers
    task automatic set_config(input logic [BR_W-1:0] br, input logic [PROF_W-1:0] prof,
                              input logic fmt);
        i_in_valid <= 1'b0;
        while (board.due.size() != 0)
            @(posedge i_clk);
        write_reg(REG_BRIGHT, br);
        write_reg(REG_PROFILE, BR_W'(prof));
        write_reg(REG_FORMAT, BR_W'(fmt));
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [CH_W-1:0] rand_chan();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return 8'h00;
        else if (r == 1)
            return 8'hff;
        return CH_W'($urandom_range(255));
    endfunction

    function automatic t_pixel_pair rand_pair();
        t_pixel_pair p;
        p.ur = rand_chan();
        p.ug = rand_chan();
        p.ub = rand_chan();
        p.lr = rand_chan();
        p.lg = rand_chan();
        p.lb = rand_chan();
        return p;
    endfunction

    // extremes, and channels either side of the luminance knee at brightness 10
    localparam t_pixel_pair PAIR_A = {8'h00, 8'hff, 8'h01, 8'h80, 8'h7f, 8'hfe};
    localparam t_pixel_pair PAIR_B = {8'hff, 8'h00, 8'hcc, 8'hcd, 8'h14, 8'h15};

    task automatic directed_pairs(input logic [BR_W-1:0] br, input logic [PROF_W-1:0] prof,
                                  input logic fmt);
        set_config(br, prof, fmt);
        send_pair(PAIR_A);
        send_pair(PAIR_B);
    endtask

    task automatic random_batch(input int n);
        logic [BR_W-1:0] br;
        int r;
        r = $urandom_range(19);
        case (r)
            0:       br = 7'd0;
            1:       br = BR_W'($urandom_range(101, 127));
            2:       br = 7'd1;
            3:       br = 7'd100;
            default: br = BR_W'($urandom_range(1, 100));
        endcase
        set_config(br, PROF_W'($urandom_range(3)), 1'($urandom_range(1)));
        repeat (n) send_pair(rand_pair());
    endtask

    // stimulus
    initial begin
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_upper_red   = '0;
        i_upper_green = '0;
        i_upper_blue  = '0;
        i_lower_red   = '0;
        i_lower_green = '0;
        i_lower_blue  = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings first, untouched
        send_pair(PAIR_A);
        send_pair(PAIR_B);

        // profiles and formats but gamma 8-bit; brightness zero, above range, the knee
        directed_pairs(7'd100, PROF_LINEAR, 1'b0);
        directed_pairs(7'd100, PROF_LINEAR, 1'b1);
        directed_pairs(7'd100, PROF_GAMMA, 1'b1);
        directed_pairs(7'd100, PROF_CIE, 1'b0);
        directed_pairs(7'd100, PROF_CIE, 1'b1);
        directed_pairs(7'd0, PROF_CIE, 1'b1);
        directed_pairs(7'd127, PROF_CIE, 1'b1);
        directed_pairs(7'd1, PROF_CIE, 1'b0);
        directed_pairs(7'd10, PROF_CIE, 1'b1);
        directed_pairs(7'd100, PROF_ALT, 1'b0);
        directed_pairs(7'd55, PROF_ALT, 1'b1);

        // random: slow receiver phase, slow sender phase, then full rate
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct = 12;
                    recv_idle_pct = 81;
                end
                1: begin
                    send_idle_pct = 81;
                    recv_idle_pct = 12;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (ph == 2) begin
                // long receiver hold while pairs keep coming, so the input backs up
                set_config(7'd100, PROF_CIE, 1'b1);
                hold_count++;
                repeat (24) send_pair(rand_pair());
            end
            for (int b = 0; b < 4; b++)
                random_batch(5);
        end

        // wait for the last words, then a margin for anything spurious
        i_in_valid <= 1'b0;
        while (board.due.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (board.errors == 0)
            $display("led_panel_pixel_pair_formatter test passed");
        else
            $display("led_panel_pixel_pair_formatter test failed");
        $finish;
    end

endmodule
